### rtl/core/heading_rate_limited_tracker_defines.svh
// Assertion macros shared by the heading tracker RTL.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef HEADING_RATE_LIMITED_TRACKER_DEFINES_SVH
`define HEADING_RATE_LIMITED_TRACKER_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while in reset.
`define HRT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled while in reset.
`define HRT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define HRT_ASSERT_IMP(lbl, ante, cons, msg)
`define HRT_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

### rtl/core/hrt_pkg.sv
// Package of the heading tracker: fixed-point constants, state and
// step codes, CORDIC handshake structs and the arctangent table.
// No dependencies.
package hrt_pkg;

  // CORDIC iteration count and datapath widths.
  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned ITER_W       = $clog2(CORDIC_STEPS);
  localparam int unsigned D_W          = 36;
  localparam int unsigned Z_W          = 28;

  // Angles in Q3.13, CORDIC angles in Q.24, gain in Q30.
  localparam logic signed [15:0]    PI_Q13      = 16'sd25736;
  localparam logic signed [17:0]    TWO_PI_Q13  = 18'sd51472;
  localparam logic signed [Z_W-1:0] HALF_PI_Q24 = 28'sd26353589;
  localparam logic signed [D_W-1:0] GAIN_Q30    = 36'sd652032874;

  // Tick qualification and seeding.
  localparam logic [31:0]        DIST_MIN = 32'd6554;
  localparam logic signed [15:0] SEED_MIN = 16'sd8;

  // Degrees times seconds to Q3.13 radians, scaled by 2^35.
  localparam logic [26:0] RATE_K        = 27'd74961353;
  localparam logic [11:0] TURN_RATE_RST = 12'd360;

  // Configuration register indexes.
  localparam logic CFG_TURN_RATE = 1'b0;
  localparam logic CFG_START_YAW = 1'b1;

  // Arctangent of 2^-i in Q.24 for the first ten steps.
  localparam logic signed [Z_W-1:0] ATAN_Q24 [10] = '{
    28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331, 28'sd1047214,
    28'sd524117,   28'sd262123,  28'sd131069,  28'sd65536,   28'sd32768
  };

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_TARGET,
    ST_SEED,
    ST_DIFF,
    ST_YAW,
    ST_SINCOS,
    ST_FINISH
  } hrt_state_e;

  // Steps of the shared multiplier.
  typedef enum logic [2:0] {
    MUL_RT,
    MUL_STEP,
    MUL_WY,
    MUL_ZX,
    MUL_XX,
    MUL_YY
  } hrt_mul_e;

  typedef struct packed {
    logic start;
    logic rotate;
  } hrt_cordic_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } hrt_cordic_rsp_t;

  // Elementary angle of step idx; beyond the table it is 2^(24-idx).
  function automatic logic signed [Z_W-1:0] hrt_atan(input logic [4:0] idx);
    logic signed [Z_W-1:0] r;
    if (idx < 5'd10) begin
      r = ATAN_Q24[idx[3:0]];
    end else begin
      r = Z_W'(1) << (5'd24 - idx);
    end
    return r;
  endfunction

endpackage

### rtl/core/heading_rate_limited_tracker.sv
// Top level of the heading tracker: stream ports, configuration, sequencer,
// shared multiplier and update arithmetic. Depends on hrt_pkg, hrt_cordic
// and heading_rate_limited_tracker_defines.svh.
//
//   channel   | direction | beat contents
//   ----------+-----------+------------------------------------------------
//   s_axis    | in        | tick inputs: offsets, distance, tick, quaternion
//   m_axis    | out       | one result per tick: yaw, sin and cos of yaw/2
//   cfg       | in        | register write: turn rate or start yaw
//
// An active tick runs the shared multiplier steps, the target atan2 pass, the
// update and the sin/cos pass on the one CORDIC unit; the first active tick
// after reset adds a seed pass when the yaw comes from the quaternion. A skipped
// tick skips all of these and goes straight to the finish state.
// The input is ready only while the sequencer is idle; a finished result sits
// in the output register, so a new tick is taken while it waits.
// Reset clears the kept yaw and loads the register defaults.
`include "heading_rate_limited_tracker_defines.svh"
module heading_rate_limited_tracker (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Input tick beat
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [31:0] corner_distance, [63:32] offset_x, [95:64] offset_z,
  // [111:96] tick_time, [127:112] orient_x, [143:128] orient_y,
  // [159:144] orient_z, [175:160] orient_w
  input  logic [175:0] s_axis_tdata,
  // [0] step_enable, [1] corner_found
  input  logic [1:0]   s_axis_tuser,
  // Result beat
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [15:0] yaw_out, [31:16] half_sine, [47:32] half_cosine
  output logic [47:0]  m_axis_tdata,
  // [0] rotation_written
  output logic         m_axis_tuser,
  // Configuration writes
  input  logic         cfg_we_i,
  input  logic         cfg_index_i,
  input  logic [15:0]  cfg_wdata_i
);

  localparam logic signed [17:0] PI18 = 18'(hrt_pkg::PI_Q13);
  localparam logic signed [hrt_pkg::D_W-1:0] ONE_Q30 = 36'sd1073741824;
  localparam logic [20:0] STEP_MAX = 21'(hrt_pkg::PI_Q13);

  // Single wrap into plus or minus pi.
  function automatic logic signed [17:0] wrap_pi(input logic signed [17:0] v);
    logic signed [17:0] r;
    r = v;
    if (r > PI18) begin
      r = r - hrt_pkg::TWO_PI_Q13;
    end
    if (r < -PI18) begin
      r = r + hrt_pkg::TWO_PI_Q13;
    end
    return r;
  endfunction

  hrt_pkg::hrt_state_e state_q, state_d;
  hrt_pkg::hrt_mul_e   mul_q, mul_d;

  logic [11:0]         turn_rate_q;
  logic signed [15:0]  start_yaw_q;
  logic signed [15:0]  smoothed_q;
  logic                yaw_ready_q;

  logic signed [31:0]  dx_q, dz_q;
  logic [15:0]         tick_q;
  logic signed [15:0]  qx_q, qy_q, qz_q, qw_q;
  logic [27:0]         rt_q;
  logic [14:0]         step_q;
  logic signed [33:0]  sy_q, cq_q;
  logic signed [15:0]  target_q;
  logic signed [17:0]  diff_q;
  logic                res_written_q;
  logic signed [15:0]  res_sin_q, res_cos_q;

  logic                out_valid_q;
  logic [47:0]         out_data_q;
  logic                out_user_q;

  logic                in_accept, skip_in, seed_reg, need_seed, out_load;
  logic signed [28:0]  a_op;
  logic signed [27:0]  b_op;
  logic signed [56:0]  prod;
  logic [55:0]         step_rnd;
  logic [20:0]         step_raw;
  logic signed [17:0]  tgt18, sm18, step18, yaw_raw, yaw_w;

  hrt_pkg::hrt_cordic_req_t         cordic_req;
  hrt_pkg::hrt_cordic_rsp_t         cordic_rsp;
  logic signed [hrt_pkg::D_W-1:0]   c_x, c_y;
  logic signed [hrt_pkg::Z_W-1:0]   c_z;
  logic signed [15:0]               c_angle, c_sin, c_cos;

  // Tick qualification and seeding source.
  assign skip_in   = !(s_axis_tuser[0] && s_axis_tuser[1]) ||
                     (s_axis_tdata[31:0] < hrt_pkg::DIST_MIN);
  assign seed_reg  = (start_yaw_q > hrt_pkg::SEED_MIN) || (start_yaw_q < -hrt_pkg::SEED_MIN);
  assign need_seed = !yaw_ready_q && !seed_reg;

  // Next state of the sequencer and of the multiplier step.
  always_comb begin
    state_d = state_q;
    mul_d   = hrt_pkg::MUL_RT;
    case (state_q)
      hrt_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = skip_in ? hrt_pkg::ST_FINISH : hrt_pkg::ST_MUL;
        end
      end
      hrt_pkg::ST_MUL: begin
        mul_d = hrt_pkg::hrt_mul_e'(mul_q + 3'd1);
        if (mul_q == hrt_pkg::MUL_YY) begin
          state_d = hrt_pkg::ST_TARGET;
          mul_d   = hrt_pkg::MUL_RT;
        end
      end
      hrt_pkg::ST_TARGET: begin
        if (cordic_rsp.done) begin
          state_d = need_seed ? hrt_pkg::ST_SEED : hrt_pkg::ST_DIFF;
        end
      end
      hrt_pkg::ST_SEED: begin
        if (cordic_rsp.done) begin
          state_d = hrt_pkg::ST_DIFF;
        end
      end
      hrt_pkg::ST_DIFF:   state_d = hrt_pkg::ST_YAW;
      hrt_pkg::ST_YAW:    state_d = hrt_pkg::ST_SINCOS;
      hrt_pkg::ST_SINCOS: begin
        if (cordic_rsp.done) begin
          state_d = hrt_pkg::ST_FINISH;
        end
      end
      hrt_pkg::ST_FINISH: begin
        if (!out_valid_q || m_axis_tready) begin
          state_d = hrt_pkg::ST_IDLE;
        end
      end
      default: state_d = hrt_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshakes and CORDIC launches.
  always_comb begin
    s_axis_tready     = (state_q == hrt_pkg::ST_IDLE);
    out_load          = (state_q == hrt_pkg::ST_FINISH) && (!out_valid_q || m_axis_tready);
    cordic_req.start  = ((state_q == hrt_pkg::ST_MUL) && (mul_q == hrt_pkg::MUL_YY)) ||
                        ((state_q == hrt_pkg::ST_TARGET) && cordic_rsp.done && need_seed) ||
                        (state_q == hrt_pkg::ST_YAW);
    cordic_req.rotate = (state_q == hrt_pkg::ST_YAW);
  end

  assign in_accept = s_axis_tvalid && s_axis_tready;

  // Shared multiplier: rate times tick, the step scale, then the quaternion terms.
  always_comb begin
    case (mul_q)
      hrt_pkg::MUL_RT: begin
        a_op = 29'(turn_rate_q);
        b_op = 28'(tick_q);
      end
      hrt_pkg::MUL_STEP: begin
        a_op = 29'(rt_q);
        b_op = 28'(hrt_pkg::RATE_K);
      end
      hrt_pkg::MUL_WY: begin
        a_op = 29'(qw_q);
        b_op = 28'(qy_q);
      end
      hrt_pkg::MUL_ZX: begin
        a_op = 29'(qz_q);
        b_op = 28'(qx_q);
      end
      hrt_pkg::MUL_XX: begin
        a_op = 29'(qx_q);
        b_op = 28'(qx_q);
      end
      hrt_pkg::MUL_YY: begin
        a_op = 29'(qy_q);
        b_op = 28'(qy_q);
      end
      default: begin
        a_op = '0;
        b_op = '0;
      end
    endcase
    prod     = a_op * b_op;
    step_rnd = 56'(prod) + (56'd1 << 34);
    step_raw = step_rnd[55:35];
  end

  // Wrapped error and the limited turn toward the target.
  always_comb begin
    tgt18  = 18'(target_q);
    sm18   = 18'(smoothed_q);
    step18 = 18'(step_q);
    if (diff_q > step18) begin
      yaw_raw = sm18 + step18;
    end else if (diff_q < -step18) begin
      yaw_raw = sm18 - step18;
    end else begin
      yaw_raw = tgt18;
    end
    yaw_w = wrap_pi(yaw_raw);
  end

  // CORDIC operands: target offsets, quaternion yaw terms or the half yaw.
  always_comb begin
    c_x = hrt_pkg::D_W'(dz_q);
    c_y = hrt_pkg::D_W'(dx_q);
    c_z = hrt_pkg::Z_W'(yaw_w) <<< 10;
    if (state_q == hrt_pkg::ST_TARGET) begin
      c_y = hrt_pkg::D_W'($signed({sy_q, 1'b0}));
      c_x = ONE_Q30 - hrt_pkg::D_W'($signed({cq_q, 1'b0}));
    end
  end

  hrt_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (cordic_req),
    .x_i     (c_x),
    .y_i     (c_y),
    .z_i     (c_z),
    .rsp_o   (cordic_rsp),
    .angle_o (c_angle),
    .sin_o   (c_sin),
    .cos_o   (c_cos)
  );

  // Control state, configuration and the kept yaw.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hrt_pkg::ST_IDLE;
      mul_q       <= hrt_pkg::MUL_RT;
      turn_rate_q <= hrt_pkg::TURN_RATE_RST;
      start_yaw_q <= '0;
      smoothed_q  <= '0;
      yaw_ready_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      mul_q   <= mul_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          hrt_pkg::CFG_TURN_RATE: turn_rate_q <= cfg_wdata_i[11:0];
          hrt_pkg::CFG_START_YAW: start_yaw_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if ((state_q == hrt_pkg::ST_TARGET) && cordic_rsp.done && !yaw_ready_q && seed_reg) begin
        smoothed_q <= start_yaw_q;
      end
      if ((state_q == hrt_pkg::ST_SEED) && cordic_rsp.done) begin
        smoothed_q <= c_angle;
      end
      if (state_q == hrt_pkg::ST_YAW) begin
        smoothed_q  <= yaw_w[15:0];
        yaw_ready_q <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Tick fields, products and intermediate results.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      dx_q          <= s_axis_tdata[63:32];
      dz_q          <= s_axis_tdata[95:64];
      tick_q        <= s_axis_tdata[111:96];
      qx_q          <= s_axis_tdata[127:112];
      qy_q          <= s_axis_tdata[143:128];
      qz_q          <= s_axis_tdata[159:144];
      qw_q          <= s_axis_tdata[175:160];
      res_written_q <= !skip_in;
      res_sin_q     <= '0;
      res_cos_q     <= '0;
    end
    if (state_q == hrt_pkg::ST_MUL) begin
      case (mul_q)
        hrt_pkg::MUL_RT:   rt_q <= prod[27:0];
        hrt_pkg::MUL_STEP: step_q <= (step_raw > STEP_MAX) ? STEP_MAX[14:0] : step_raw[14:0];
        hrt_pkg::MUL_WY:   sy_q <= 34'(prod);
        hrt_pkg::MUL_ZX:   sy_q <= sy_q - 34'(prod);
        hrt_pkg::MUL_XX:   cq_q <= 34'(prod);
        hrt_pkg::MUL_YY:   cq_q <= cq_q + 34'(prod);
        default: ;
      endcase
    end
    if ((state_q == hrt_pkg::ST_TARGET) && cordic_rsp.done) begin
      target_q <= c_angle;
    end
    if (state_q == hrt_pkg::ST_DIFF) begin
      diff_q <= wrap_pi(tgt18 - sm18);
    end
    if ((state_q == hrt_pkg::ST_SINCOS) && cordic_rsp.done) begin
      res_sin_q <= c_sin;
      res_cos_q <= c_cos;
    end
    if (out_load) begin
      out_data_q <= {res_cos_q, res_sin_q, smoothed_q};
      out_user_q <= res_written_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // Cross-checks between the sequencer, the CORDIC unit and the kept yaw.
  `HRT_ASSERT_IMP(a_start_idle, cordic_req.start, !cordic_rsp.busy, "CORDIC launched while busy")
  `HRT_ASSERT_IMP(a_done_in_wait, cordic_rsp.done, (state_q == hrt_pkg::ST_TARGET) || (state_q == hrt_pkg::ST_SEED) || (state_q == hrt_pkg::ST_SINCOS), "CORDIC result outside a waiting state")
  `HRT_ASSERT_IMP(a_yaw_wrapped, (state_q == hrt_pkg::ST_IDLE) && yaw_ready_q, (smoothed_q <= hrt_pkg::PI_Q13) && (smoothed_q >= -hrt_pkg::PI_Q13), "kept yaw outside plus or minus pi")
  `HRT_ASSERT_NXT(a_ready_after_update, state_q == hrt_pkg::ST_YAW, yaw_ready_q && (state_q == hrt_pkg::ST_SINCOS), "yaw update did not mark the yaw as ready")

endmodule

### rtl/core/hrt_cordic.sv
// Shared CORDIC unit: vectoring (atan2) or rotation (sin/cos), one step a cycle.
// Depends on hrt_pkg and heading_rate_limited_tracker_defines.svh.
`include "heading_rate_limited_tracker_defines.svh"
module hrt_cordic (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  hrt_pkg::hrt_cordic_req_t          req_i,
  input  logic signed [hrt_pkg::D_W-1:0]    x_i,
  input  logic signed [hrt_pkg::D_W-1:0]    y_i,
  input  logic signed [hrt_pkg::Z_W-1:0]    z_i,
  output hrt_pkg::hrt_cordic_rsp_t          rsp_o,
  output logic signed [15:0]                angle_o,
  output logic signed [15:0]                sin_o,
  output logic signed [15:0]                cos_o
);

  localparam logic [hrt_pkg::ITER_W-1:0] LAST_ITER = hrt_pkg::ITER_W'(hrt_pkg::CORDIC_STEPS - 1);
  localparam logic signed [hrt_pkg::Z_W:0] Z_RND  = (hrt_pkg::Z_W+1)'(1024);
  localparam logic signed [hrt_pkg::Z_W:0] Z_PI   = (hrt_pkg::Z_W+1)'(hrt_pkg::PI_Q13);
  localparam logic signed [hrt_pkg::D_W:0] D_RND  = (hrt_pkg::D_W+1)'(16384);
  localparam logic signed [hrt_pkg::D_W:0] D_MAX  = (hrt_pkg::D_W+1)'(32767);
  localparam logic signed [hrt_pkg::D_W:0] D_MIN  = -(hrt_pkg::D_W+1)'(32768);

  logic                            busy_q, done_q, rot_q, zero_q;
  logic [hrt_pkg::ITER_W-1:0]      iter_q;
  logic signed [hrt_pkg::D_W-1:0]  x_q, y_q, x0, y0, xs, ys, x_n, y_n;
  logic signed [hrt_pkg::Z_W-1:0]  z_q, z0, z_n, a_step;
  logic                            sub_x;
  logic signed [hrt_pkg::Z_W:0]    z_ext, z_sum, z_shr;
  logic signed [hrt_pkg::D_W:0]    y_ext, y_sum, y_shr, x_ext, x_sum, x_shr;

  // Initial vector: fixed gain for rotation, half-plane fold for vectoring.
  always_comb begin
    x0 = x_i;
    y0 = y_i;
    z0 = '0;
    if (req_i.rotate) begin
      x0 = hrt_pkg::GAIN_Q30;
      y0 = '0;
      z0 = z_i;
    end else if (x_i < 0) begin
      if (y_i >= 0) begin
        x0 = y_i;
        y0 = -x_i;
        z0 = hrt_pkg::HALF_PI_Q24;
      end else begin
        x0 = -y_i;
        y0 = x_i;
        z0 = -hrt_pkg::HALF_PI_Q24;
      end
    end
  end

  // One micro-rotation; the direction follows y when vectoring and z when rotating.
  always_comb begin
    xs     = x_q >>> iter_q;
    ys     = y_q >>> iter_q;
    a_step = hrt_pkg::hrt_atan(5'(iter_q));
    sub_x  = rot_q ? !z_q[hrt_pkg::Z_W-1] : y_q[hrt_pkg::D_W-1];
    if (sub_x) begin
      x_n = x_q - ys;
      y_n = y_q + xs;
      z_n = z_q - a_step;
    end else begin
      x_n = x_q + ys;
      y_n = y_q - xs;
      z_n = z_q + a_step;
    end
  end

  // Sequencing of the iterations.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
      rot_q  <= 1'b0;
      zero_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        iter_q <= '0;
        rot_q  <= req_i.rotate;
        zero_q <= !req_i.rotate && (x_i == 0) && (y_i == 0);
      end else if (busy_q) begin
        if (iter_q == LAST_ITER) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
          iter_q <= '0;
        end else begin
          iter_q <= iter_q + 1'b1;
        end
      end
    end
  end

  // Vector and angle registers.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      x_q <= x0;
      y_q <= y0;
      z_q <= z0;
    end else if (busy_q) begin
      x_q <= x_n;
      y_q <= y_n;
      z_q <= z_n;
    end
  end

  // Rounded and saturated results, valid while done is high.
  always_comb begin
    z_ext = (hrt_pkg::Z_W+1)'(z_q);
    z_sum = z_ext + Z_RND;
    z_shr = z_sum >>> 11;
    if (zero_q) begin
      angle_o = '0;
    end else if (z_shr > Z_PI) begin
      angle_o = hrt_pkg::PI_Q13;
    end else if (z_shr < -Z_PI) begin
      angle_o = -hrt_pkg::PI_Q13;
    end else begin
      angle_o = z_shr[15:0];
    end

    y_ext = (hrt_pkg::D_W+1)'(y_q);
    y_sum = y_ext + D_RND;
    y_shr = y_sum >>> 15;
    if (y_shr > D_MAX) begin
      sin_o = 16'sh7fff;
    end else if (y_shr < D_MIN) begin
      sin_o = -16'sh8000;
    end else begin
      sin_o = y_shr[15:0];
    end

    x_ext = (hrt_pkg::D_W+1)'(x_q);
    x_sum = x_ext + D_RND;
    x_shr = x_sum >>> 15;
    if (x_shr > D_MAX) begin
      cos_o = 16'sh7fff;
    end else if (x_shr < D_MIN) begin
      cos_o = -16'sh8000;
    end else begin
      cos_o = x_shr[15:0];
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;

  // Done is a single-cycle pulse and the step counter rests at zero when idle.
  `HRT_ASSERT_NXT(a_done_pulse, done_q, !done_q, "CORDIC done held longer than one cycle")
  `HRT_ASSERT_IMP(a_iter_idle, !busy_q, iter_q == '0, "CORDIC step counter moved while idle")
  `HRT_ASSERT_NXT(a_done_after_run, busy_q && (iter_q == LAST_ITER) && !req_i.start, done_q, "CORDIC run ended without done")

endmodule

### verif/tb_heading_rate_limited_tracker.sv
// Self-checking testbench for heading_rate_limited_tracker: stream stimulus with random
// idling, turn-rate and start-yaw settings, and a bit-exact predictor of the yaw update.
// Depends on hrt_pkg and the heading_rate_limited_tracker RTL.
`timescale 1ns / 1ps

module tb_heading_rate_limited_tracker;

  // Fixed-point constants of the heading update (Q3.13 angles, Q.24 CORDIC angles).
  localparam longint          PI_Q13        = 25736;
  localparam longint          TWO_PI_Q13    = 51472;
  localparam longint          HALF_PI_Q24   = 26353589;
  localparam longint          ROT_GAIN_Q30  = 652032874;
  localparam longint          DIST_FLOOR    = 6554;
  localparam longint          SEED_FLOOR    = 8;
  localparam longint unsigned DEG_TO_Q13_K  = 74961353;
  localparam int              CORDIC_PASSES = 16;

  localparam int HOLD_CYCLES    = 400;
  localparam int STALL_LIMIT    = 5000;
  localparam int DRAIN_CYCLES   = 64;
  localparam int PHASE_TICKS    = 220;

  // One tick as the sender sees it.
  typedef struct packed {
    logic               step_enable;
    logic               corner_found;
    logic [31:0]        corner_distance;
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_z;
    logic [15:0]        tick_time;
    logic signed [15:0] orient_x;
    logic signed [15:0] orient_y;
    logic signed [15:0] orient_z;
    logic signed [15:0] orient_w;
  } tick_beat_t;

  // One heading result.
  typedef struct packed {
    logic        rotation_written;
    logic [15:0] yaw_out;
    logic [15:0] half_sine;
    logic [15:0] half_cosine;
  } heading_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  // [31:0] corner_distance, [63:32] offset_x, [95:64] offset_z, [111:96] tick_time,
  // [127:112] orient_x, [143:128] orient_y, [159:144] orient_z, [175:160] orient_w
  logic [175:0] s_axis_tdata;
  // [0] step_enable, [1] corner_found
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  // [15:0] yaw_out, [31:16] half_sine, [47:32] half_cosine
  logic [47:0]  m_axis_tdata;
  // [0] rotation_written
  logic         m_axis_tuser;
  logic         cfg_we_i;
  logic         cfg_index_i;
  logic [15:0]  cfg_wdata_i;

  // Predictor state and its copy of the registers.
  longint      kept_yaw       = 0;
  bit          yaw_seeded     = 1'b0;
  logic [11:0] rate_limit_deg = 12'd360;
  longint      seed_yaw       = 0;

  heading_t    heading_q[$];
  heading_t    due;

  bit steady        = 1'b0;
  bit hold_request  = 1'b0;
  int mismatches    = 0;
  int headings_seen = 0;
  int ticks_turning = 0;
  int ticks_skipped = 0;
  int rate_settings = 0;
  int stall_cycles  = 0;

  heading_rate_limited_tracker i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // Clock with a 2 ns period.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Elementary CORDIC angle of pass i in Q.24.
  function automatic longint elem_angle(int i);
    longint r;
    case (i)
      0:       r = 13176795;
      1:       r = 7778716;
      2:       r = 4110060;
      3:       r = 2086331;
      4:       r = 1047214;
      5:       r = 524117;
      6:       r = 262123;
      7:       r = 131069;
      8:       r = 65536;
      9:       r = 32768;
      default: r = (i <= 24) ? (64'sd1 << (24 - i)) : 0;
    endcase
    return r;
  endfunction

  function automatic longint saturate(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Vectoring pass: angle of the vector (x, y) in Q3.13, zero for the null vector.
  function automatic longint cordic_bearing(longint y, longint x);
    longint ang, t, xs, ys;
    int     i;
    ang = 0;
    if (x == 0 && y == 0) return 0;
    // Fold the left half-plane by a quarter turn.
    if (x < 0) begin
      if (y >= 0) begin
        t = y; y = -x; x = t; ang = HALF_PI_Q24;
      end else begin
        t = -y; y = x; x = t; ang = -HALF_PI_Q24;
      end
    end
    for (i = 0; i < CORDIC_PASSES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y < 0) begin
        x = x - ys; y = y + xs; ang = ang - elem_angle(i);
      end else begin
        x = x + ys; y = y - xs; ang = ang + elem_angle(i);
      end
    end
    return saturate((ang + 1024) >>> 11, -PI_Q13, PI_Q13);
  endfunction

  // Rotation pass: sine and cosine in Q1.15 of an angle given in Q.24.
  function automatic void half_angle_sincos(input longint ang, output longint sn,
                                            output longint cs);
    longint x, y, xs, ys;
    int     i;
    x = ROT_GAIN_Q30;
    y = 0;
    for (i = 0; i < CORDIC_PASSES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (ang >= 0) begin
        x = x - ys; y = y + xs; ang = ang - elem_angle(i);
      end else begin
        x = x + ys; y = y - xs; ang = ang + elem_angle(i);
      end
    end
    sn = saturate((y + 16384) >>> 15, -32768, 32767);
    cs = saturate((x + 16384) >>> 15, -32768, 32767);
  endfunction

  // Turns the kept yaw for one tick and returns the heading the block should emit.
  function automatic heading_t advance_heading(tick_beat_t b);
    heading_t        r;
    longint          target, diff, turn_step, yaw, mag, qx, qy, qz, qw, sn, cs;
    longint unsigned span;
    r.rotation_written = 1'b0;
    r.yaw_out          = kept_yaw[15:0];
    r.half_sine        = '0;
    r.half_cosine      = '0;
    if (b.step_enable && b.corner_found && b.corner_distance >= DIST_FLOOR) begin
      target = cordic_bearing(longint'($signed(b.offset_x)), longint'($signed(b.offset_z)));
      // The first turning tick seeds the yaw from the register or the quaternion.
      if (!yaw_seeded) begin
        mag = (seed_yaw < 0) ? -seed_yaw : seed_yaw;
        if (mag > SEED_FLOOR) begin
          kept_yaw = seed_yaw;
        end else begin
          qx = longint'($signed(b.orient_x));
          qy = longint'($signed(b.orient_y));
          qz = longint'($signed(b.orient_z));
          qw = longint'($signed(b.orient_w));
          kept_yaw = cordic_bearing(2 * (qw * qy - qz * qx),
                                    64'sd1073741824 - 2 * (qx * qx + qy * qy));
        end
        yaw_seeded = 1'b1;
      end
      diff = target - kept_yaw;
      if (diff > PI_Q13) diff = diff - TWO_PI_Q13;
      if (diff < -PI_Q13) diff = diff + TWO_PI_Q13;
      span = rate_limit_deg * b.tick_time * DEG_TO_Q13_K + (64'd1 << 34);
      turn_step = $signed(span >> 35);
      if (turn_step > PI_Q13) turn_step = PI_Q13;
      if (diff > turn_step || diff < -turn_step) begin
        yaw = kept_yaw + ((diff > 0) ? turn_step : -turn_step);
      end else begin
        yaw = target;
      end
      if (yaw > PI_Q13) yaw = yaw - TWO_PI_Q13;
      if (yaw < -PI_Q13) yaw = yaw + TWO_PI_Q13;
      kept_yaw = yaw;
      half_angle_sincos(yaw * 1024, sn, cs);
      r.rotation_written = 1'b1;
      r.yaw_out          = yaw[15:0];
      r.half_sine        = sn[15:0];
      r.half_cosine      = cs[15:0];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offset with magnitudes spread over the whole range, extremes included.
  function automatic logic [31:0] spread32();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(9))
      0:       v = 32'h8000_0000;
      1:       v = 32'h7fff_ffff;
      2:       v = '0;
      default: v = $signed(v) >>> $urandom_range(31, 0);
    endcase
    return v;
  endfunction

  function automatic tick_beat_t make_tick(logic en, logic found, logic [31:0] corner_dist,
                                           logic [31:0] dx, logic [31:0] dz,
                                           logic [15:0] dt);
    tick_beat_t b;
    b.step_enable     = en;
    b.corner_found    = found;
    b.corner_distance = corner_dist;
    b.offset_x        = dx;
    b.offset_z        = dz;
    b.tick_time       = dt;
    b.orient_x        = 16'($urandom);
    b.orient_y        = 16'($urandom);
    b.orient_z        = 16'($urandom);
    b.orient_w        = 16'($urandom);
    return b;
  endfunction

  // Mostly turning ticks; about one in seven is skipped for one of its three reasons.
  function automatic tick_beat_t random_tick();
    tick_beat_t b;
    b = make_tick(1'b1, 1'b1, $urandom, spread32(), spread32(), 16'($urandom));
    if ($urandom_range(3) == 0) b.corner_distance = $urandom_range(7000, 6554);
    else if (b.corner_distance < DIST_FLOOR)
      b.corner_distance = 32'(b.corner_distance + DIST_FLOOR);
    if ($urandom_range(1) == 0) b.tick_time = 16'($urandom_range(2000, 0));
    case ($urandom_range(19))
      0:       b.step_enable = 1'b0;
      1:       b.corner_found = 1'b0;
      2:       b.corner_distance = $urandom_range(6553, 0);
      default: ;
    endcase
    return b;
  endfunction

  // Offers one tick, with random gaps first, and predicts its heading on acceptance.
  task automatic send_tick(tick_beat_t b);
    heading_t h;
    while (!steady && $urandom_range(99) < 26) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b.orient_w, b.orient_z, b.orient_y, b.orient_x, b.tick_time,
                      b.offset_z, b.offset_x, b.corner_distance};
    s_axis_tuser  <= {b.corner_found, b.step_enable};
    do @(posedge clk_i); while (!s_axis_tready);
    h = advance_heading(b);
    heading_q = {heading_q, h};
    if (h.rotation_written) ticks_turning++;
    else ticks_skipped++;
  endtask

  // Waits until every heading has come back, then lets the block settle.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (heading_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [15:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == hrt_pkg::CFG_TURN_RATE) rate_limit_deg = data[11:0];
    else seed_yaw = longint'($signed(data));
    @(posedge clk_i);
  endtask

  // Runs of ticks that head for the same corner, so the yaw can settle on it.
  task automatic run_random_ticks(int count);
    tick_beat_t  b;
    logic [31:0] ox, oz;
    int          left;
    left = 0;
    repeat (count) begin
      if (left == 0) begin
        ox   = spread32();
        oz   = spread32();
        left = $urandom_range(8, 1);
      end
      b = random_tick();
      if ($urandom_range(4) != 0) begin
        b.offset_x = ox;
        b.offset_z = oz;
      end
      left--;
      send_tick(b);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Skipped ticks before any seeding: the held yaw is still the reset value.
  task automatic test_skips_before_seed();
    send_tick(make_tick(1'b0, 1'b1, 32'hffff_ffff, spread32(), spread32(), 16'($urandom)));
    send_tick(make_tick(1'b1, 1'b0, 32'hffff_ffff, spread32(), spread32(), 16'($urandom)));
    send_tick(make_tick(1'b1, 1'b1, 32'd0, spread32(), spread32(), 16'($urandom)));
    send_tick(make_tick(1'b1, 1'b1, 32'd6553, spread32(), spread32(), 16'($urandom)));
  endtask

  // The first turning tick seeds the yaw, from the register or from the quaternion.
  task automatic test_first_tick_seed();
    logic [15:0] seed;
    tick_beat_t  b;
    wait_idle();
    case ($urandom_range(11))
      0:       seed = 16'd0;
      1:       seed = 16'd8;
      2:       seed = -16'sd8;
      3:       seed = 16'($urandom_range(16, 0) - 8);
      4:       seed = 16'd1;
      5:       seed = 16'd9;
      6:       seed = -16'sd9;
      7:       seed = 16'd25736;
      8:       seed = -16'sd25736;
      9:       seed = 16'h7fff;
      10:      seed = 16'h8000;
      default: seed = 16'($urandom);
    endcase
    write_reg(hrt_pkg::CFG_START_YAW, seed);
    b = random_tick();
    b.step_enable     = 1'b1;
    b.corner_found    = 1'b1;
    b.corner_distance = 32'd6554;
    case ($urandom_range(3))
      0: {b.orient_x, b.orient_y, b.orient_z, b.orient_w} = '0;
      1: {b.orient_x, b.orient_y, b.orient_z, b.orient_w} = {4{16'h8000}};
      2: {b.orient_x, b.orient_y, b.orient_z, b.orient_w} = {4{16'h7fff}};
      default: ;
    endcase
    send_tick(b);
    send_tick(make_tick(1'b1, 1'b1, $urandom | 32'h10000, spread32(), spread32(),
                        16'($urandom)));
  endtask

  // Field extremes, the zero offset, each half-plane of the bearing and the wrap at pi.
  task automatic test_field_extremes();
    send_tick(make_tick(1'b1, 1'b1, 32'd6554, 32'd0, 32'd0, 16'hffff));
    send_tick(make_tick(1'b1, 1'b1, 32'hffff_ffff, 32'h7fff_ffff, 32'd0, 16'h0000));
    send_tick(make_tick(1'b1, 1'b1, 32'hffff_ffff, 32'd0, 32'h8000_0000, 16'hffff));
    send_tick(make_tick(1'b1, 1'b1, 32'h0001_0000, 32'h8000_0000, 32'h8000_0000, 16'hffff));
    send_tick(make_tick(1'b1, 1'b1, 32'h0001_0000, 32'h8000_0000, 32'h7fff_ffff, 16'h8000));
    send_tick(make_tick(1'b1, 1'b1, 32'h0001_0000, 32'h0000_0001, 32'hffff_ffff, 16'h0100));
    send_tick(make_tick(1'b0, 1'b0, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 16'hffff));
    send_tick(make_tick(1'b1, 1'b1, 32'd6553, 32'h7fff_ffff, 32'h8000_0000, 16'hffff));
    send_tick(make_tick(1'b1, 1'b1, 32'h0002_0000, 32'hffff_ffff, 32'hffff_8000, 16'hffff));
    send_tick(make_tick(1'b1, 1'b1, 32'h0002_0000, 32'h0000_0001, 32'hffff_8000, 16'h1000));
    send_tick(make_tick(1'b1, 1'b1, 32'h0002_0000, 32'hffff_ffff, 32'hffff_8000, 16'h0800));
  endtask

  // Random phases under different turn rates; start-yaw writes no longer take effect.
  task automatic test_turn_rates();
    logic [11:0] rate;
    logic [15:0] seed;
    int          k;
    for (k = 0; k < 6; k++) begin
      case (k)
        0:       begin rate = 12'd0;          seed = -16'sd25736;   end
        1:       begin rate = 12'd1;          seed = 16'd25736;     end
        2:       begin rate = 12'd3600;       seed = 16'h8000;      end
        3:       begin rate = 12'd4095;       seed = 16'h7fff;      end
        4:       begin rate = 12'($urandom);  seed = 16'($urandom); end
        default: begin rate = 12'd360;        seed = 16'd0;         end
      endcase
      wait_idle();
      write_reg(hrt_pkg::CFG_TURN_RATE, {4'd0, rate});
      write_reg(hrt_pkg::CFG_START_YAW, seed);
      rate_settings++;
      run_random_ticks(PHASE_TICKS);
    end
  endtask

  // Back-to-back beats with neither side idling.
  task automatic test_steady_stream();
    wait_idle();
    write_reg(hrt_pkg::CFG_TURN_RATE, {4'd0, 12'($urandom_range(3600, 0))});
    rate_settings++;
    steady = 1'b1;
    run_random_ticks(200);
    steady = 1'b0;
  endtask

  // The receiver holds off while ticks keep coming, so the block stalls its input.
  task automatic test_output_backpressure();
    hold_request = 1'b1;
    run_random_ticks(180);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver, checker and watchdog
  // ---------------------------------------------------------------------------

  // Result ready: random stalls, a steady stretch and one long hold-off.
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_request = 1'b0;
      end
      m_axis_tready <= steady || ($urandom_range(99) >= 26);
    end
  end

  // Each result beat is compared with the oldest predicted heading.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (heading_q.size() == 0) begin
        $error("Result beat with no tick outstanding: yaw_out %0d",
               $signed(m_axis_tdata[15:0]));
        mismatches++;
      end else begin
        due = heading_q.pop_front();
        headings_seen++;
        if (m_axis_tuser !== due.rotation_written) begin
          $error("rotation_written: expected %0d, got %0d", due.rotation_written, m_axis_tuser);
          mismatches++;
        end
        if (m_axis_tdata[15:0] !== due.yaw_out) begin
          $error("yaw_out: expected %0d, got %0d", $signed(due.yaw_out),
                 $signed(m_axis_tdata[15:0]));
          mismatches++;
        end
        if (m_axis_tdata[31:16] !== due.half_sine) begin
          $error("half_sine: expected %0d, got %0d", $signed(due.half_sine),
                 $signed(m_axis_tdata[31:16]));
          mismatches++;
        end
        if (m_axis_tdata[47:32] !== due.half_cosine) begin
          $error("half_cosine: expected %0d, got %0d", $signed(due.half_cosine),
                 $signed(m_axis_tdata[47:32]));
          mismatches++;
        end
      end
    end
  end

  // Ends the run if no beat and no register write moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Timeout: no beat for %0d cycles, %0d headings outstanding.",
               STALL_LIMIT, heading_q.size());
      $display("** heading_rate_limited_tracker: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= hrt_pkg::CFG_TURN_RATE;
    cfg_wdata_i   <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_skips_before_seed();
    test_first_tick_seed();
    test_field_extremes();
    test_turn_rates();
    test_steady_stream();
    test_output_backpressure();

    // Drain, then keep watching for stray beats.
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d ticks (%0d turning, %0d skipped) under %0d turn-rate settings.",
             ticks_turning + ticks_skipped, ticks_turning, ticks_skipped, rate_settings);
    $display("Checked %0d headings, with a %0d-cycle output hold-off along the way.",
             headings_seen, HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("** heading_rate_limited_tracker: PASSED **");
    end else begin
      $display("** heading_rate_limited_tracker: FAILED **");
    end
    $finish;
  end

endmodule

### heading_rate_limited_tracker.f
+incdir+rtl/core
rtl/core/hrt_pkg.sv
rtl/core/hrt_cordic.sv
rtl/core/heading_rate_limited_tracker.sv
verif/tb_heading_rate_limited_tracker.sv
